// ===== hw/rtl/cclm_pkg.sv =====
// Shared constants, register indexes and types for the CCLM luma
// downsample and linear-model chroma predictor. No dependencies.
`timescale 1ns / 1ps

package cclm_pkg;

	// Default luma / chroma sample width
	localparam int SAMPLE_BITS_DEF = 10;
	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Configuration port geometry
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	// Linear model register widths
	localparam int SCALE_W  = 16;
	localparam int SHIFT_W  = 5;
	localparam int OFFSET_W = 32;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_LEFT_AVAIL = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CB_SCALE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CB_SHIFT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CB_OFFSET  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CR_SCALE   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CR_SHIFT   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CR_OFFSET  = 3'd6;

	// Linear model for one chroma component
	typedef struct packed {
		logic signed [SCALE_W-1:0]  scale;
		logic [SHIFT_W-1:0]         shift;
		logic signed [OFFSET_W-1:0] offset;
	} model_t;

endpackage

// ===== hw/rtl/cclm_luma_downsample_predict.sv =====
// CCLM predictor top level: configuration registers, filter front end,
// decoupling queue and linear-model back end. Depends on cclm_pkg,
// cclm_front, cclm_queue and cclm_back.
// Throughput: one item per cycle unless the queue fills or out_stall
// holds the result, set by the combinational front filter and the
// two-stage multiply / clamp back end.
// Reset: asynchronous, active low; clears registers, neighbours, queue.
`timescale 1ns / 1ps

module cclm_luma_downsample_predict #(
	parameter int SAMPLE_BITS = cclm_pkg::SAMPLE_BITS_DEF,
	parameter int QUEUE_DEPTH = cclm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cclm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [cclm_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [SAMPLE_BITS-1:0]            top_even,
	input  logic [SAMPLE_BITS-1:0]            top_odd,
	input  logic [SAMPLE_BITS-1:0]            bottom_even,
	input  logic [SAMPLE_BITS-1:0]            bottom_odd,
	input  logic                              row_start,
	input  logic [SAMPLE_BITS-1:0]            left_top,
	input  logic [SAMPLE_BITS-1:0]            left_bottom,
	// results
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [SAMPLE_BITS-1:0]            cb_pred,
	output logic [SAMPLE_BITS-1:0]            cr_pred
);

	logic                   left_avail_q;
	cclm_pkg::model_t       cb_model_q;
	cclm_pkg::model_t       cr_model_q;
	logic                   q_full;
	logic                   q_not_empty;
	logic                   push;
	logic                   pop;
	logic [SAMPLE_BITS-1:0] push_data;
	logic [SAMPLE_BITS-1:0] q_head;

	// configuration registers; writes always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_avail_q <= 1'b0;
			cb_model_q   <= '0;
			cr_model_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cclm_pkg::REG_LEFT_AVAIL: left_avail_q <= cfg_data[0];
				cclm_pkg::REG_CB_SCALE: cb_model_q.scale <= cfg_data[cclm_pkg::SCALE_W-1:0];
				cclm_pkg::REG_CB_SHIFT: cb_model_q.shift <= cfg_data[cclm_pkg::SHIFT_W-1:0];
				cclm_pkg::REG_CB_OFFSET: cb_model_q.offset <= cfg_data[cclm_pkg::OFFSET_W-1:0];
				cclm_pkg::REG_CR_SCALE: cr_model_q.scale <= cfg_data[cclm_pkg::SCALE_W-1:0];
				cclm_pkg::REG_CR_SHIFT: cr_model_q.shift <= cfg_data[cclm_pkg::SHIFT_W-1:0];
				cclm_pkg::REG_CR_OFFSET: cr_model_q.offset <= cfg_data[cclm_pkg::OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// filter front end
	cclm_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.top_even      (top_even),
		.top_odd       (top_odd),
		.bottom_even   (bottom_even),
		.bottom_odd    (bottom_odd),
		.row_start     (row_start),
		.left_top      (left_top),
		.left_bottom   (left_bottom),
		.left_available(left_avail_q),
		.q_full        (q_full),
		.push          (push),
		.push_data     (push_data)
	);

	// decoupling queue
	cclm_queue #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	// linear model back end
	cclm_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_not_empty),
		.q_data   (q_head),
		.pop      (pop),
		.cb_model (cb_model_q),
		.cr_model (cr_model_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cb_pred  (cb_pred),
		.cr_pred  (cr_pred)
	);

endmodule

// ===== hw/rtl/cclm_front.sv =====
// Front end: accepts luma items, resolves the left neighbour column and
// forms the 6-tap downsampled luma value. Depends on cclm_pkg.
`timescale 1ns / 1ps

module cclm_front #(
	parameter int SAMPLE_BITS = cclm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input item channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] top_even,
	input  logic [SAMPLE_BITS-1:0] top_odd,
	input  logic [SAMPLE_BITS-1:0] bottom_even,
	input  logic [SAMPLE_BITS-1:0] bottom_odd,
	input  logic                   row_start,
	input  logic [SAMPLE_BITS-1:0] left_top,
	input  logic [SAMPLE_BITS-1:0] left_bottom,
	// configuration
	input  logic                   left_available,
	// queue push side
	input  logic                   q_full,
	output logic                   push,
	output logic [SAMPLE_BITS-1:0] push_data
);

	localparam int ACC_W = SAMPLE_BITS + 3;

	logic [SAMPLE_BITS-1:0] prev_top_q;
	logic [SAMPLE_BITS-1:0] prev_bottom_q;
	logic [SAMPLE_BITS-1:0] lt;
	logic [SAMPLE_BITS-1:0] lb;
	logic [ACC_W-1:0]       acc;

	// transfer happens whenever the queue has room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// left neighbour: previous odd column inside a row, else edge column or padding
	always_comb begin
		if (row_start) begin
			if (left_available) begin
				lt = left_top;
				lb = left_bottom;
			end else begin
				lt = top_even;
				lb = bottom_even;
			end
		end else begin
			lt = prev_top_q;
			lb = prev_bottom_q;
		end
	end

	// [1 2 1; 1 2 1] filter with rounding, divided by 8
	assign acc = ACC_W'(lt) + ACC_W'({top_even, 1'b0}) + ACC_W'(top_odd)
		+ ACC_W'(lb) + ACC_W'({bottom_even, 1'b0}) + ACC_W'(bottom_odd)
		+ ACC_W'(4);
	assign push_data = acc[ACC_W-1:3];

	// odd samples become the next item's left neighbours
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_top_q    <= '0;
			prev_bottom_q <= '0;
		end else if (push) begin
			prev_top_q    <= top_odd;
			prev_bottom_q <= bottom_odd;
		end
	end

endmodule

// ===== hw/rtl/cclm_queue.sv =====
// Short FIFO decoupling the filter front end from the model back end.
// Depends on cclm_pkg for default sizes.
`timescale 1ns / 1ps

module cclm_queue #(
	parameter int WIDTH = cclm_pkg::SAMPLE_BITS_DEF,
	parameter int DEPTH = cclm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/cclm_back.sv =====
// Back end: applies the Cb and Cr linear models (multiply, arithmetic
// shift, offset, clamp) in two stages. Depends on cclm_pkg.
`timescale 1ns / 1ps

module cclm_back #(
	parameter int SAMPLE_BITS = cclm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// queue pop side
	input  logic                   q_valid,
	input  logic [SAMPLE_BITS-1:0] q_data,
	output logic                   pop,
	// models
	input  cclm_pkg::model_t       cb_model,
	input  cclm_pkg::model_t       cr_model,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] cb_pred,
	output logic [SAMPLE_BITS-1:0] cr_pred
);

	localparam int PROD_W = SAMPLE_BITS + 1 + cclm_pkg::SCALE_W;
	localparam int OFS_W  = cclm_pkg::OFFSET_W;

	logic                     valid_s1;
	logic signed [PROD_W-1:0] cb_prod_s1;
	logic signed [PROD_W-1:0] cr_prod_s1;
	logic signed [PROD_W-1:0] cb_prod;
	logic signed [PROD_W-1:0] cr_prod;
	logic                     out_valid_q;
	logic [SAMPLE_BITS-1:0]   cb_pred_q;
	logic [SAMPLE_BITS-1:0]   cr_pred_q;
	logic                     ready_out;
	logic                     ready_s1;

	// floor shift, 32-bit wrapping offset add, clamp to sample range
	function automatic logic [SAMPLE_BITS-1:0] apply_model(
		input logic signed [PROD_W-1:0]            prod,
		input logic [cclm_pkg::SHIFT_W-1:0]        shift,
		input logic signed [OFS_W-1:0]             offset
	);
		logic signed [PROD_W-1:0] sh;
		logic [OFS_W-1:0]         ext;
		logic [OFS_W-1:0]         v;
		sh  = prod >>> shift;
		ext = {{(OFS_W - PROD_W){sh[PROD_W-1]}}, sh};
		v   = ext + offset;
		if (v[OFS_W-1]) begin
			return '0;
		end else if (|v[OFS_W-2:SAMPLE_BITS]) begin
			return '1;
		end else begin
			return v[SAMPLE_BITS-1:0];
		end
	endfunction

	// stage handshake
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s1  = !valid_s1 || ready_out;
	assign pop       = q_valid && ready_s1;

	// stage 1 multiply
	assign cb_prod = $signed({1'b0, q_data}) * cb_model.scale;
	assign cr_prod = $signed({1'b0, q_data}) * cr_model.scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= q_valid;
			end
			if (ready_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cb_prod_s1 <= cb_prod;
			cr_prod_s1 <= cr_prod;
		end
	end

	// stage 2 shift, offset and clamp into the output register
	always_ff @(posedge clk) begin
		if (ready_out && valid_s1) begin
			cb_pred_q <= apply_model(cb_prod_s1, cb_model.shift, cb_model.offset);
			cr_pred_q <= apply_model(cr_prod_s1, cr_model.shift, cr_model.offset);
		end
	end

	assign out_valid = out_valid_q;
	assign cb_pred   = cb_pred_q;
	assign cr_pred   = cr_pred_q;

endmodule
